### rtl/mwd_pkg.sv
`timescale 1ns / 1ps
// Package for the magic word message deframer: payload structs, queue entry,
// phase enum, framing constants. No dependencies.
package mwd_pkg;

    localparam int MAX_MSG_BYTES_DEFAULT = 65536;
    localparam int QUEUE_DEPTH_DEFAULT   = 4;

    localparam int MSG_LEN_W = 17;
    typedef logic [MSG_LEN_W-1:0] msg_len_t;
    localparam msg_len_t MAX_LEN_RESET = 17'h10000;

    localparam logic [7:0]  MAGIC_B0   = 8'hAF;
    localparam logic [7:0]  MAGIC_B1   = 8'hFE;
    localparam logic [7:0]  MAGIC_B2   = 8'hC0;
    localparam logic [7:0]  MAGIC_B3   = 8'hC2;
    localparam logic [15:0] MAGIC_P2   = 16'hAFFE;
    localparam logic [23:0] MAGIC_HEAD = 24'hAFFEC0;

    localparam logic [3:0]  HDR_MAGIC_LEN  = 4'd4;
    localparam logic [3:0]  HDR_SIZE_FIRST = 4'd8;
    localparam logic [3:0]  HDR_LEN        = 4'd12;
    localparam logic [32:0] MSG_OVERHEAD   = 33'd24;
    localparam logic [32:0] HDR_LEN_W      = 33'd12;

    typedef enum logic [1:0] {
        PH_HUNT   = 2'd0,
        PH_HEADER = 2'd1,
        PH_BODY   = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        packet_last;
        logic [63:0] packet_time;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        msg_first;
        logic        msg_last;
        logic        frame_error;
        logic [63:0] msg_time;
        logic        run_last;
    } out_item_t;

    // One queue entry: either a whole magic word burst or one message byte.
    typedef struct packed {
        logic        is_magic;
        logic [7:0]  data;
        logic        msg_last;
        logic        frame_error;
        logic [63:0] msg_time;
    } cmd_t;

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] b;
        unique case (idx)
            2'd0:    b = MAGIC_B0;
            2'd1:    b = MAGIC_B1;
            2'd2:    b = MAGIC_B2;
            default: b = MAGIC_B3;
        endcase
        return b;
    endfunction

endpackage

### rtl/mwd_front.sv
`timescale 1ns / 1ps
// Front end: hunts for the magic word, tracks header and body, stamps times.
// Pushes one queue entry per accepted byte that causes results. Uses mwd_pkg.
module mwd_front #(
    parameter int MAX_MSG_BYTES = mwd_pkg::MAX_MSG_BYTES_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  mwd_pkg::in_item_t item,
    input  mwd_pkg::msg_len_t max_len,
    output logic             cmd_valid,
    output mwd_pkg::cmd_t    cmd
);
    import mwd_pkg::*;

    localparam int BR_W = $clog2(MAX_MSG_BYTES + 1);
    localparam logic [32:0] LIMIT_CAP = 33'(MAX_MSG_BYTES);

    phase_t          phase_reg, phase_next;
    logic [23:0]     recent_reg, recent_next;
    logic [3:0]      hidx_reg, hidx_next;
    logic [31:0]     size_reg, size_next;
    logic [BR_W-1:0] br_reg, br_next;
    logic            pend_flag_reg, pend_flag_next;
    logic [63:0]     pend_time_reg, pend_time_next;

    logic [31:0]     size_upd;
    logic [3:0]      hidx_inc;
    logic [32:0]     total;
    logic [32:0]     limit;
    logic [BR_W-1:0] br_dec;
    logic [63:0]     time_sel;
    logic            take;
    logic            pend_kept;
    logic            prefix;
    logic            unconsumed;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            recent_reg    <= '0;
            hidx_reg      <= '0;
            size_reg      <= '0;
            br_reg        <= '0;
            pend_flag_reg <= 1'b0;
            pend_time_reg <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            recent_reg    <= recent_next;
            hidx_reg      <= hidx_next;
            size_reg      <= size_next;
            br_reg        <= br_next;
            pend_flag_reg <= pend_flag_next;
            pend_time_reg <= pend_time_next;
        end
    end

    assign size_upd = (hidx_reg >= HDR_SIZE_FIRST) ? {size_reg[23:0], item.data_byte} : size_reg;
    assign hidx_inc = hidx_reg + 4'd1;
    assign total    = {1'b0, size_upd} + MSG_OVERHEAD;
    assign limit    = ({16'b0, max_len} > LIMIT_CAP) ? LIMIT_CAP : {16'b0, max_len};
    assign br_dec   = (br_reg != '0) ? br_reg - BR_W'(1) : br_reg;
    assign time_sel = pend_flag_reg ? pend_time_reg : item.packet_time;

    always_comb
    begin
        phase_next     = phase_reg;
        recent_next    = recent_reg;
        hidx_next      = hidx_reg;
        size_next      = size_reg;
        br_next        = br_reg;
        pend_flag_next = pend_flag_reg;
        pend_time_next = pend_time_reg;
        cmd_valid      = 1'b0;
        cmd            = '{is_magic: 1'b0, data: item.data_byte, msg_last: 1'b0,
                           frame_error: 1'b0, msg_time: 64'd0};
        take           = 1'b0;
        pend_kept      = 1'b0;
        prefix         = 1'b0;
        unconsumed     = 1'b0;
        if (accept)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (recent_reg == MAGIC_HEAD && item.data_byte == MAGIC_B3)
                    begin
                        cmd_valid    = 1'b1;
                        cmd.is_magic = 1'b1;
                        phase_next   = PH_HEADER;
                        hidx_next    = HDR_MAGIC_LEN;
                        size_next    = '0;
                        recent_next  = '0;
                    end
                    else
                    begin
                        recent_next = {recent_reg[15:0], item.data_byte};
                    end
                end
                PH_HEADER:
                begin
                    cmd_valid = 1'b1;
                    size_next = size_upd;
                    if (hidx_inc >= HDR_LEN)
                    begin
                        hidx_next = '0;
                        if (total > limit)
                        begin
                            // too long: abort on the last header byte
                            take            = 1'b1;
                            cmd.msg_last    = 1'b1;
                            cmd.frame_error = 1'b1;
                            cmd.msg_time    = time_sel;
                            phase_next      = PH_HUNT;
                            recent_next     = '0;
                        end
                        else
                        begin
                            br_next    = BR_W'(total - HDR_LEN_W);
                            phase_next = PH_BODY;
                        end
                    end
                    else
                    begin
                        hidx_next = hidx_inc;
                    end
                end
                PH_BODY:
                begin
                    cmd_valid = 1'b1;
                    br_next   = br_dec;
                    if (br_dec == '0)
                    begin
                        take         = 1'b1;
                        cmd.msg_last = 1'b1;
                        cmd.msg_time = time_sel;
                        phase_next   = PH_HUNT;
                        recent_next  = '0;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase

            pend_kept  = pend_flag_reg & ~take;
            prefix     = (recent_next[7:0] == MAGIC_B0) || (recent_next[15:0] == MAGIC_P2) ||
                         (recent_next == MAGIC_HEAD);
            unconsumed = (phase_next != PH_HUNT) || prefix;
            pend_flag_next = pend_kept;
            if (item.packet_last && unconsumed && !pend_kept)
            begin
                pend_flag_next = 1'b1;
                pend_time_next = item.packet_time;
            end
        end
    end

endmodule

### rtl/mwd_queue.sv
`timescale 1ns / 1ps
// Short queue of front-end entries between the front and back ends.
// Uses mwd_pkg.
module mwd_queue #(
    parameter int DEPTH = mwd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  mwd_pkg::cmd_t wr_data,
    output logic          full,
    output logic          rd_valid,
    input  logic          rd_ready,
    output mwd_pkg::cmd_t rd_data
);
    import mwd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign full     = (count_reg == CNT_FULL);
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk) begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### rtl/mwd_back.sv
`timescale 1ns / 1ps
// Back end: expands queue entries into result beats, one per cycle while the
// output is free or taken, into an output register. Uses mwd_pkg.
module mwd_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  mwd_pkg::cmd_t      cmd,
    output logic               out_valid,
    input  logic               out_take,
    output mwd_pkg::out_item_t out_item
);
    import mwd_pkg::*;

    logic       out_valid_reg, out_valid_next;
    out_item_t  out_reg, out_next;
    logic [1:0] bidx_reg, bidx_next;
    logic       load;

    assign load      = !out_valid_reg || out_take;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        bidx_next      = bidx_reg;
        cmd_ready      = 1'b0;
        if (load)
        begin
            out_valid_next = cmd_valid;
            if (cmd_valid)
            begin
                if (cmd.is_magic)
                begin
                    out_next = '{out_byte: magic_byte(bidx_reg), msg_first: (bidx_reg == 2'd0),
                                 msg_last: 1'b0, frame_error: 1'b0, msg_time: 64'd0,
                                 run_last: (bidx_reg == 2'd3)};
                    cmd_ready = (bidx_reg == 2'd3);
                    bidx_next = bidx_reg + 2'd1;
                end
                else
                begin
                    out_next = '{out_byte: cmd.data, msg_first: 1'b0, msg_last: cmd.msg_last,
                                 frame_error: cmd.frame_error, msg_time: cmd.msg_time,
                                 run_last: 1'b1};
                    cmd_ready = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            bidx_reg      <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            bidx_reg      <= bidx_next;
        end
    end

    always_ff @(posedge clk) begin
        out_reg <= out_next;
    end

endmodule

### rtl/magic_word_message_deframer_top.sv
`timescale 1ns / 1ps
// Top level of the magic word message deframer: front end, entry queue,
// back end and the max length register. Uses mwd_pkg and all mwd_ modules.
//
// Bytes are taken at one per clock cycle while full is low. A completed magic
// word yields four result beats, which the back end sends from one queue
// entry; with the default QUEUE_DEPTH of 4 this stalls the input (full high)
// when header bytes follow back to back. Beyond that, full rises only when the
// entry queue backs up behind a stalled result side. Every other message byte
// yields one beat. A result is written into the entry queue when its byte is
// accepted and then into the output register. Messages longer than the
// smaller of the length register and MAX_MSG_BYTES end on their twelfth byte
// with frame_error set. There is no clearing pass after reset.
module magic_word_message_deframer_top #(
    parameter int MAX_MSG_BYTES = mwd_pkg::MAX_MSG_BYTES_DEFAULT,
    parameter int QUEUE_DEPTH   = mwd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  mwd_pkg::in_item_t  item,
    output logic               empty,
    input  logic               pop,
    output mwd_pkg::out_item_t result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  mwd_pkg::msg_len_t  cfg_data
);
    import mwd_pkg::*;

    msg_len_t max_len_reg;
    logic     accept;
    logic     f_valid;
    cmd_t     f_cmd;
    logic     q_valid;
    logic     q_ready;
    cmd_t     q_cmd;
    logic     out_valid;

    assign cfg_ready = 1'b1;
    assign accept    = push && !full;
    assign empty     = !out_valid;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_len_reg <= cfg_data;
        end
    end

    mwd_front #(
        .MAX_MSG_BYTES(MAX_MSG_BYTES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (item),
        .max_len  (max_len_reg),
        .cmd_valid(f_valid),
        .cmd      (f_cmd)
    );

    mwd_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (f_valid),
        .wr_data (f_cmd),
        .full    (full),
        .rd_valid(q_valid),
        .rd_ready(q_ready),
        .rd_data (q_cmd)
    );

    mwd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(q_valid),
        .cmd_ready(q_ready),
        .cmd      (q_cmd),
        .out_valid(out_valid),
        .out_take (pop),
        .out_item (result)
    );

    a_first_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && result.msg_first |-> !result.msg_last)
        else $error("first beat of a message also marked last");

    a_error_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && result.frame_error |-> result.msg_last && result.run_last)
        else $error("frame_error outside the last beat");

    a_time_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !result.msg_last |-> result.msg_time == 64'd0)
        else $error("msg_time set on a beat that is not last");

    a_first_from_queue: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && result.msg_first && pop |=> !empty && !result.msg_first)
        else $error("magic word burst broken after its first beat");

endmodule

### tb/magic_word_message_deframer_top_tb.sv
`timescale 1ns / 1ps
// Testbench for magic_word_message_deframer_top: directed and random byte streams,
// with a built-in framing predictor checking every result beat. Uses mwd_pkg.
module magic_word_message_deframer_top_tb;
    import mwd_pkg::*;

    localparam logic [32:0] MAX_BYTES = 33'(MAX_MSG_BYTES_DEFAULT);
    localparam int EXP_DEPTH    = 1024;
    localparam int STREAM_DEPTH = 512;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      push;
    logic      full;
    in_item_t  item;
    logic      empty;
    logic      pop = 1'b0;
    out_item_t result;
    logic      cfg_valid;
    logic      cfg_ready;
    msg_len_t  cfg_data;

    magic_word_message_deframer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // framing predictor state
    logic [23:0] hunt_window = '0;
    phase_t      cur_phase   = PH_HUNT;
    logic [3:0]  hdr_count   = '0;
    logic [31:0] size_acc    = '0;
    logic [16:0] body_left   = '0;
    logic        pend_valid  = 1'b0;
    logic [63:0] pend_stamp  = '0;
    msg_len_t    len_limit   = MAX_LEN_RESET;

    // expected beats, written at exp_wr and read at exp_rd
    out_item_t   exp_mem[EXP_DEPTH];
    int          exp_wr = 0;
    int          exp_rd = 0;
    int          mismatches = 0;

    int          send_idle_pct = 0;
    int          pop_stall_pct = 0;
    logic [63:0] pkt_stamp;
    logic [7:0]  stream_mem[STREAM_DEPTH];
    int          stream_len = 0;
    int          framed_bytes;

    function automatic out_item_t make_beat(logic [7:0] b, logic first, logic lastm,
                                            logic err, logic [63:0] stamp);
        out_item_t r;
        r.out_byte    = b;
        r.msg_first   = first;
        r.msg_last    = lastm;
        r.frame_error = err;
        r.msg_time    = stamp;
        r.run_last    = 1'b0;
        return r;
    endfunction

    function automatic void add_expected(out_item_t b);
        exp_mem[exp_wr % EXP_DEPTH] = b;
        exp_wr++;
    endfunction

    function automatic void stream_add(logic [7:0] x);
        stream_mem[stream_len] = x;
        stream_len++;
    endfunction

    function automatic logic [63:0] message_stamp(logic [63:0] now);
        logic [63:0] s;
        s = pend_valid ? pend_stamp : now;
        pend_valid = 1'b0;
        return s;
    endfunction

    function automatic void frame_byte(in_item_t it);
        int          first_wr;
        logic [32:0] total;
        logic [32:0] limit;
        logic        held;
        first_wr = exp_wr;
        if (cur_phase == PH_HUNT)
        begin
            if (hunt_window == MAGIC_HEAD && it.data_byte == MAGIC_B3)
            begin
                add_expected(make_beat(MAGIC_B0, 1'b1, 1'b0, 1'b0, '0));
                add_expected(make_beat(MAGIC_B1, 1'b0, 1'b0, 1'b0, '0));
                add_expected(make_beat(MAGIC_B2, 1'b0, 1'b0, 1'b0, '0));
                add_expected(make_beat(MAGIC_B3, 1'b0, 1'b0, 1'b0, '0));
                cur_phase   = PH_HEADER;
                hdr_count   = HDR_MAGIC_LEN;
                size_acc    = '0;
                hunt_window = '0;
            end
            else
                hunt_window = {hunt_window[15:0], it.data_byte};
        end
        else if (cur_phase == PH_HEADER)
        begin
            if (hdr_count >= HDR_SIZE_FIRST)
                size_acc = {size_acc[23:0], it.data_byte};
            hdr_count = hdr_count + 4'd1;
            if (hdr_count >= HDR_LEN)
            begin
                total = {1'b0, size_acc} + MSG_OVERHEAD;
                limit = (33'(len_limit) > MAX_BYTES) ? MAX_BYTES : 33'(len_limit);
                if (total > limit)
                begin
                    add_expected(make_beat(it.data_byte, 1'b0, 1'b1, 1'b1,
                                           message_stamp(it.packet_time)));
                    cur_phase   = PH_HUNT;
                    hunt_window = '0;
                end
                else
                begin
                    add_expected(make_beat(it.data_byte, 1'b0, 1'b0, 1'b0, '0));
                    body_left = 17'(total - HDR_LEN_W);
                    cur_phase = PH_BODY;
                end
                hdr_count = '0;
            end
            else
                add_expected(make_beat(it.data_byte, 1'b0, 1'b0, 1'b0, '0));
        end
        else
        begin
            if (body_left > 0)
                body_left = body_left - 17'd1;
            if (body_left == 0)
            begin
                add_expected(make_beat(it.data_byte, 1'b0, 1'b1, 1'b0,
                                       message_stamp(it.packet_time)));
                cur_phase   = PH_HUNT;
                hunt_window = '0;
            end
            else
                add_expected(make_beat(it.data_byte, 1'b0, 1'b0, 1'b0, '0));
        end

        held = (cur_phase != PH_HUNT) || hunt_window[7:0] == MAGIC_B0 ||
               hunt_window[15:0] == MAGIC_P2 || hunt_window == MAGIC_HEAD;
        if (it.packet_last && held && !pend_valid)
        begin
            pend_stamp = it.packet_time;
            pend_valid = 1'b1;
        end

        if (exp_wr != first_wr)
            exp_mem[(exp_wr - 1) % EXP_DEPTH].run_last = 1'b1;
    endfunction

    function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    function automatic void check_beat(out_item_t act);
        out_item_t exp_b;
        if (exp_wr == exp_rd)
        begin
            $display("%0t: unexpected beat: expected none, actual %h", $time, act);
            mismatches++;
        end
        else
        begin
            exp_b = exp_mem[exp_rd % EXP_DEPTH];
            exp_rd++;
            check_field("out_byte", 64'(exp_b.out_byte), 64'(act.out_byte));
            check_field("msg_first", 64'(exp_b.msg_first), 64'(act.msg_first));
            check_field("msg_last", 64'(exp_b.msg_last), 64'(act.msg_last));
            check_field("frame_error", 64'(exp_b.frame_error), 64'(act.frame_error));
            check_field("msg_time", exp_b.msg_time, act.msg_time);
            check_field("run_last", 64'(exp_b.run_last), 64'(act.run_last));
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                len_limit = cfg_data;
            if (pop && !empty)
                check_beat(result);
            if (push && !full)
                frame_byte(item);
        end
    end

    always @(negedge clk)
        pop <= ($urandom_range(99) >= pop_stall_pct);

    task automatic send_byte(input logic [7:0] b, input logic plast, input logic [63:0] stamp);
        in_item_t it;
        it.data_byte   = b;
        it.packet_last = plast;
        it.packet_time = stamp;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic send_stream();
        logic plast;
        for (int i = 0; i < stream_len; i++)
        begin
            plast = ($urandom_range(7) == 0);
            send_byte(stream_mem[i], plast, pkt_stamp);
            if (plast)
                pkt_stamp = {$urandom, $urandom};
        end
        stream_len = 0;
    endtask

    task automatic drain();
        @(negedge clk);
        push <= 1'b0;
        while (exp_wr != exp_rd)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_max_len(input msg_len_t v);
        drain();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // split prefix held over a packet end, overlapping magic word, shortest
    // message with the magic word inside its body, stamp taken from the pending packet
    task automatic test_min_message_pending_stamp();
        logic [63:0] t_hi;
        logic [7:0]  body[12];
        t_hi = '1;
        body = '{MAGIC_B0, MAGIC_B1, MAGIC_B2, MAGIC_B3, 8'hFF, 8'h00,
                 8'h55, 8'hAA, 8'h01, 8'h80, 8'h7F, 8'hFF};
        send_byte(8'h00, 1'b1, '0);
        send_byte(MAGIC_B0, 1'b1, t_hi);
        send_byte(MAGIC_B0, 1'b0, '0);
        send_byte(MAGIC_B1, 1'b0, '0);
        send_byte(MAGIC_B2, 1'b0, '0);
        send_byte(MAGIC_B3, 1'b0, '0);
        send_byte(8'hFF, 1'b0, '0);
        send_byte(8'h00, 1'b0, '0);
        send_byte(8'hFF, 1'b0, '0);
        send_byte(8'h00, 1'b0, '0);
        repeat (4) send_byte(8'h00, 1'b0, '0);
        foreach (body[i])
            send_byte(body[i], (i == 5), (i == 11) ? '0 : t_hi);
        send_byte(MAGIC_B3, 1'b0, '0);
    endtask

    // largest size field: the length sum must not wrap, so the frame aborts
    task automatic test_oversize_without_wrap();
        logic [63:0] t_hi;
        t_hi = '1;
        send_byte(MAGIC_B0, 1'b0, '0);
        send_byte(MAGIC_B1, 1'b0, '0);
        send_byte(MAGIC_B2, 1'b0, '0);
        send_byte(MAGIC_B3, 1'b0, '0);
        repeat (4) send_byte(8'h00, 1'b0, '0);
        repeat (3) send_byte(8'hFF, 1'b0, '0);
        send_byte(8'hFF, 1'b1, t_hi);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input msg_len_t limit, input int n_bytes);
        int          noise;
        logic [7:0]  x;
        logic [31:0] size;
        logic [32:0] total;
        int          sel;
        write_max_len(limit);
        send_idle_pct = idle_pct;
        pop_stall_pct = stall_pct;
        framed_bytes  = 0;
        while (framed_bytes < n_bytes)
        begin
            noise = $urandom_range(0, 3);
            repeat (noise)
            begin
                sel = $urandom_range(0, 3);
                x = (sel == 0) ? MAGIC_B0 : (sel == 1) ? MAGIC_B1 :
                    (sel == 2) ? MAGIC_B2 : 8'($urandom);
                stream_add(x);
            end
            if ($urandom_range(0, 7) == 0)
            begin
                do x = 8'($urandom); while (x == MAGIC_B3);
                stream_add(MAGIC_B0);
                stream_add(MAGIC_B1);
                stream_add(MAGIC_B2);
                stream_add(x);
            end
            stream_add(MAGIC_B0);
            stream_add(MAGIC_B1);
            stream_add(MAGIC_B2);
            stream_add(MAGIC_B3);
            repeat (4) stream_add(8'($urandom));
            sel = $urandom_range(0, 99);
            if (sel < 15)
                size = $urandom;
            else if (sel < 30 && limit <= 300)
                size = 32'(limit) - 32'd24 + 32'($urandom_range(0, 1));
            else
                size = $urandom_range(0, 40);
            stream_add(size[31:24]);
            stream_add(size[23:16]);
            stream_add(size[15:8]);
            stream_add(size[7:0]);
            framed_bytes += 12;
            total = {1'b0, size} + MSG_OVERHEAD;
            if (total <= 33'(limit))
            begin
                repeat (int'(total) - 12)
                begin
                    sel = $urandom_range(0, 7);
                    x = (sel == 0) ? MAGIC_B0 : (sel == 1) ? MAGIC_B3 : 8'($urandom);
                    stream_add(x);
                end
                framed_bytes += int'(total) - 12;
            end
            send_stream();
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        push      = 1'b0;
        item      = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        pkt_stamp = {$urandom, $urandom};
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_min_message_pending_stamp();
        test_oversize_without_wrap();
        test_random_traffic(0, 0, 17'd65536, 50);
        test_random_traffic(50, 0, 17'd24, 50);
        test_random_traffic(0, 50, 17'($urandom_range(25, 120)), 50);
        test_random_traffic(36, 36, 17'd300, 25);

        drain();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && exp_wr == exp_rd)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("FAILURE");
        $finish;
    end

endmodule

### magic_word_message_deframer_top.f
rtl/mwd_pkg.sv
rtl/mwd_front.sv
rtl/mwd_queue.sv
rtl/mwd_back.sv
rtl/magic_word_message_deframer_top.sv
tb/magic_word_message_deframer_top_tb.sv
